@@ hw/rtl/ogrt_pkg.sv @@
package ogrt_pkg;

    // Widths fixed by the item fields
    localparam int CFG_W     = 9;    // map_width / map_height
    localparam int CFG_IDX_W = 1;    // two registers
    localparam int CELL_W    = 8;
    localparam int RAY_W     = 16;

    // Clip datapath: endpoints stay inside the 16-bit input range while clipping,
    // differences need one more bit, one guard bit on top.
    localparam int COORD_W = 18;
    localparam int PROD_W  = 2 * COORD_W;
    // Walk datapath: clipped coordinates are below 511
    localparam int WALK_W  = 9;
    localparam int ERR_W   = 12;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAP_WIDTH  = 1'b0,
        CFG_MAP_HEIGHT = 1'b1
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CODE,
        ST_CLIP,
        ST_MUL,
        ST_DSTART,
        ST_DIV,
        ST_APPLY,
        ST_WSET,
        ST_WALK,
        ST_OUT
    } t_state;

    typedef enum logic [2:0] {
        STEP_Y1,
        STEP_Y2,
        STEP_CHK,
        STEP_X1,
        STEP_X2
    } t_clip_step;

    // Classified item as queued between front and back
    typedef struct packed {
        logic                    trace;    // 1: trace a ray, 0: cell write
        logic                    wr_keep;  // cell write lands inside the store
        logic                    occ;      // written byte nonzero
        logic [CELL_W-1:0]       cx;
        logic [CELL_W-1:0]       cy;
        logic signed [RAY_W-1:0] sx;
        logic signed [RAY_W-1:0] sy;
        logic signed [RAY_W-1:0] ex;
        logic signed [RAY_W-1:0] ey;
    } t_cmd;

endpackage

@@ hw/rtl/ogrt_if.sv @@
interface ogrt_in_if import ogrt_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic                    kind;
    logic [CELL_W-1:0]       cell_x;
    logic [CELL_W-1:0]       cell_y;
    logic [CELL_W-1:0]       cell_value;
    logic signed [RAY_W-1:0] ray_start_x;
    logic signed [RAY_W-1:0] ray_start_y;
    logic signed [RAY_W-1:0] ray_end_x;
    logic signed [RAY_W-1:0] ray_end_y;

    modport source (output valid, kind, cell_x, cell_y, cell_value,
                    ray_start_x, ray_start_y, ray_end_x, ray_end_y,
                    input ready);
    modport sink (input valid, kind, cell_x, cell_y, cell_value,
                  ray_start_x, ray_start_y, ray_end_x, ray_end_y,
                  output ready);
endinterface

interface ogrt_out_if import ogrt_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              inside_res;
    logic              hit;
    logic [CELL_W-1:0] hit_x;
    logic [CELL_W-1:0] hit_y;
    logic [CELL_W-1:0] clipped_start_x;
    logic [CELL_W-1:0] clipped_start_y;
    logic [CELL_W-1:0] clipped_end_x;
    logic [CELL_W-1:0] clipped_end_y;

    modport source (output valid, inside_res, hit, hit_x, hit_y, clipped_start_x,
                    clipped_start_y, clipped_end_x, clipped_end_y,
                    input ready);
    modport sink (input valid, inside_res, hit, hit_x, hit_y, clipped_start_x,
                  clipped_start_y, clipped_end_x, clipped_end_y,
                  output ready);
endinterface

interface ogrt_cfg_if import ogrt_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] addr;
    logic [CFG_W-1:0]     data;

    modport source (output valid, addr, data, input ready);
    modport sink (input valid, addr, data, output ready);
endinterface

@@ hw/rtl/ogrt_ram.sv @@
module ogrt_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

@@ hw/rtl/ogrt_div.sv @@
// Signed divide, truncating toward zero, one quotient bit per cycle.
// Divide by zero returns zero.
module ogrt_div #(
    parameter int N_W = 36,
    parameter int D_W = 18
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic signed [N_W-1:0] i_num,
    input  logic signed [D_W-1:0] i_den,
    output logic                  o_done,
    output logic signed [N_W-1:0] o_quo
);
    localparam int CNT_W = $clog2(N_W + 1);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [N_W-1:0]   r_q;
    logic [D_W-1:0]   r_rem;
    logic [D_W-1:0]   r_ud;
    logic             r_neg;
    logic             r_zero;
    logic [D_W:0]     sh;
    logic             qbit;

    always_comb begin
        sh   = {r_rem, r_q[N_W-1]};
        qbit = (sh >= {1'b0, r_ud});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(N_W);
                r_q    <= i_num[N_W-1] ? N_W'(-i_num) : N_W'(i_num);
                r_ud   <= i_den[D_W-1] ? D_W'(-i_den) : D_W'(i_den);
                r_rem  <= '0;
                r_neg  <= i_num[N_W-1] ^ i_den[D_W-1];
                r_zero <= (i_den == '0);
            end else if (r_busy) begin
                r_rem <= qbit ? D_W'(sh - {1'b0, r_ud}) : sh[D_W-1:0];
                r_q   <= {r_q[N_W-2:0], qbit};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    assign o_quo = r_zero ? '0 : (r_neg ? -$signed(r_q) : $signed(r_q));
endmodule

@@ hw/rtl/ogrt_front.sv @@
// Input side: takes beats, sorts them into cell writes and traces, and
// queues them for the back end.
module ogrt_front import ogrt_pkg::*; #(
    parameter int MAX_SIDE = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ogrt_in_if.sink     i_in,
    input  logic        i_hold,
    input  logic        i_pop,
    output logic        o_cmd_valid,
    output t_cmd        o_cmd
);
    t_cmd       r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       push;
    t_cmd       cmd_in;

    always_comb begin
        cmd_in.trace   = i_in.kind;
        cmd_in.wr_keep = (32'(i_in.cell_x) < MAX_SIDE) && (32'(i_in.cell_y) < MAX_SIDE);
        cmd_in.occ     = (i_in.cell_value != '0);
        cmd_in.cx      = i_in.cell_x;
        cmd_in.cy      = i_in.cell_y;
        cmd_in.sx      = i_in.ray_start_x;
        cmd_in.sy      = i_in.ray_start_y;
        cmd_in.ex      = i_in.ray_end_x;
        cmd_in.ey      = i_in.ray_end_y;
    end

    assign i_in.ready  = (r_cnt != 2'd2) && !i_hold;
    assign push        = i_in.valid && i_in.ready;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cmd_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, i_pop};
        end
    end
endmodule

@@ hw/rtl/ogrt_back.sv @@
// Execution side: cell writes, clip sequencer with shared multiplier and
// divider, Bresenham walk over the occupancy RAM, result register.
module ogrt_back import ogrt_pkg::*; #(
    parameter int MAX_SIDE = 256
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cmd_valid,
    input  t_cmd             i_cmd,
    output logic             o_cmd_pop,
    output logic             o_hold,
    input  logic [CFG_W-1:0] i_map_w,
    input  logic [CFG_W-1:0] i_map_h,
    ogrt_out_if.source       o_out
);
    localparam int AW     = $clog2(MAX_SIDE);
    localparam int ADDR_W = 2 * AW;
    localparam int DEPTH  = 1 << ADDR_W;

    t_state r_state, n_state;
    logic [ADDR_W-1:0] r_clr;

    logic [CFG_W-1:0] eff_w, eff_h;
    logic [CFG_W-1:0] r_right, r_bottom;

    logic signed [COORD_W-1:0] r_x1, r_y1, r_x2, r_y2;
    logic [3:0]                r_c1, r_c2, code1, code2;
    t_clip_step                r_step;
    logic signed [COORD_W-1:0] r_a, r_ma, r_mb, r_den, clip_a, rs, bs;
    logic signed [PROD_W-1:0]  r_prod;
    logic                      div_start, div_done;
    logic signed [PROD_W-1:0]  div_quo;
    logic signed [COORD_W-1:0] q, nx1, nx2;

    // walk
    logic [WALK_W-1:0]       r_wx, r_wy, r_px, r_py;
    logic                    r_pv, r_sxn, r_syn, r_swap;
    logic signed [ERR_W-1:0] r_err, r_inc_a, r_inc_b;
    logic [WALK_W:0]         r_left;
    logic signed [WALK_W:0]  dx, dy;
    logic [WALK_W-1:0]       adx, ady, maj, mnr;
    logic                    wneg;

    logic              r_inside, r_hit;
    logic [WALK_W-1:0] r_hx, r_hy;
    logic              hit_now, out_free;

    logic              ram_we, ram_wdata, ram_rdata;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;

    logic r_ov, r_oin, r_ohit;
    logic [CELL_W-1:0] r_ohx, r_ohy, r_osx, r_osy, r_oex, r_oey;

    function automatic logic [3:0] out_code(input logic signed [COORD_W-1:0] x,
                                            input logic signed [COORD_W-1:0] y,
                                            input logic signed [COORD_W-1:0] rt,
                                            input logic signed [COORD_W-1:0] bt);
        return {y > bt, y < 0, x > rt, x < 0};
    endfunction

    ogrt_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    ogrt_div #(.N_W(PROD_W), .D_W(COORD_W)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_prod),
        .i_den   (r_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    always_comb begin
        eff_w = (32'(i_map_w) > MAX_SIDE) ? CFG_W'(MAX_SIDE) : i_map_w;
        eff_h = (32'(i_map_h) > MAX_SIDE) ? CFG_W'(MAX_SIDE) : i_map_h;
        rs    = $signed(COORD_W'(r_right));
        bs    = $signed(COORD_W'(r_bottom));
        code1 = out_code(r_x1, r_y1, rs, bs);
        code2 = out_code(r_x2, r_y2, rs, bs);
        q     = $signed(div_quo[COORD_W-1:0]);
        nx1   = r_x1 + q;
        nx2   = r_x2 + q;
        case (r_step)
            STEP_Y1: clip_a = r_c1[3] ? bs : '0;
            STEP_Y2: clip_a = r_c2[3] ? bs : '0;
            STEP_X1: clip_a = r_c1[0] ? '0 : rs;
            STEP_X2: clip_a = r_c2[0] ? '0 : rs;
            default: clip_a = '0;
        endcase
        dx   = $signed({1'b0, r_x2[WALK_W-1:0]}) - $signed({1'b0, r_x1[WALK_W-1:0]});
        dy   = $signed({1'b0, r_y2[WALK_W-1:0]}) - $signed({1'b0, r_y1[WALK_W-1:0]});
        adx  = dx[WALK_W] ? WALK_W'(-dx) : dx[WALK_W-1:0];
        ady  = dy[WALK_W] ? WALK_W'(-dy) : dy[WALK_W-1:0];
        maj  = (ady > adx) ? ady : adx;
        mnr  = (ady > adx) ? adx : ady;
        wneg = r_err[ERR_W-1];
        hit_now  = r_pv && ram_rdata;
        out_free = !r_ov || o_out.ready;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR:  if (r_clr == '1) n_state = ST_IDLE;
            ST_IDLE: begin
                if (i_cmd_valid && i_cmd.trace) begin
                    n_state = (eff_w == '0 || eff_h == '0) ? ST_OUT : ST_CODE;
                end
            end
            ST_CODE: begin
                if ((code1 & code2) != 4'd0)      n_state = ST_OUT;
                else if ((code1 | code2) == 4'd0) n_state = ST_WSET;
                else                              n_state = ST_CLIP;
            end
            ST_CLIP: begin
                case (r_step)
                    STEP_Y1: if (r_c1[3:2] != 2'd0) n_state = ST_MUL;
                    STEP_Y2: if (r_c2[3:2] != 2'd0) n_state = ST_MUL;
                    STEP_CHK: begin
                        if (!((r_c1 & r_c2) == 4'd0 && (r_c1 | r_c2) != 4'd0)) begin
                            n_state = ((r_c1 | r_c2) == 4'd0) ? ST_WSET : ST_OUT;
                        end
                    end
                    STEP_X1: if (r_c1 != 4'd0) n_state = ST_MUL;
                    default: n_state = (r_c2 != 4'd0) ? ST_MUL : ST_WSET;
                endcase
            end
            ST_MUL:    n_state = ST_DSTART;
            ST_DSTART: n_state = ST_DIV;
            ST_DIV:    if (div_done) n_state = ST_APPLY;
            ST_APPLY:  n_state = ST_CLIP;
            ST_WSET:   n_state = ST_WALK;
            ST_WALK:   if (hit_now || r_left == '0) n_state = ST_OUT;
            ST_OUT:    if (out_free) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_cmd_pop = (r_state == ST_IDLE) && i_cmd_valid;
        o_hold    = (r_state == ST_CLEAR);
        div_start = (r_state == ST_DSTART);
        if (r_state == ST_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr;
            ram_wdata = 1'b0;
        end else begin
            ram_we    = o_cmd_pop && !i_cmd.trace && i_cmd.wr_keep;
            ram_waddr = (ADDR_W'(i_cmd.cy) << AW) | ADDR_W'(i_cmd.cx);
            ram_wdata = i_cmd.occ;
        end
        ram_raddr = (ADDR_W'(r_wy) << AW) | ADDR_W'(r_wx);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (r_state == ST_OUT && out_free) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_x1     <= $signed({{(COORD_W-RAY_W){i_cmd.sx[RAY_W-1]}}, i_cmd.sx});
                r_y1     <= $signed({{(COORD_W-RAY_W){i_cmd.sy[RAY_W-1]}}, i_cmd.sy});
                r_x2     <= $signed({{(COORD_W-RAY_W){i_cmd.ex[RAY_W-1]}}, i_cmd.ex});
                r_y2     <= $signed({{(COORD_W-RAY_W){i_cmd.ey[RAY_W-1]}}, i_cmd.ey});
                r_right  <= eff_w - 1'b1;
                r_bottom <= eff_h - 1'b1;
                r_inside <= 1'b0;
                r_hit    <= 1'b0;
            end
            ST_CODE: begin
                r_c1   <= code1;
                r_c2   <= code2;
                r_step <= STEP_Y1;
            end
            ST_CLIP: begin
                r_a <= clip_a;
                case (r_step)
                    STEP_Y1: begin
                        r_ma  <= clip_a - r_y1;
                        r_mb  <= r_x2 - r_x1;
                        r_den <= r_y2 - r_y1;
                        if (r_c1[3:2] == 2'd0) r_step <= STEP_Y2;
                    end
                    STEP_Y2: begin
                        r_ma  <= clip_a - r_y2;
                        r_mb  <= r_x2 - r_x1;
                        r_den <= r_y2 - r_y1;
                        if (r_c2[3:2] == 2'd0) r_step <= STEP_CHK;
                    end
                    STEP_CHK: r_step <= STEP_X1;
                    STEP_X1: begin
                        r_ma  <= clip_a - r_x1;
                        r_mb  <= r_y2 - r_y1;
                        r_den <= r_x2 - r_x1;
                        if (r_c1 == 4'd0) r_step <= STEP_X2;
                    end
                    default: begin
                        r_ma  <= clip_a - r_x2;
                        r_mb  <= r_y2 - r_y1;
                        r_den <= r_x2 - r_x1;
                    end
                endcase
            end
            ST_MUL: r_prod <= r_ma * r_mb;
            ST_APPLY: begin
                case (r_step)
                    STEP_Y1: begin
                        r_x1   <= nx1;
                        r_y1   <= r_a;
                        r_c1   <= {2'b00, nx1 > rs, nx1 < 0};
                        r_step <= STEP_Y2;
                    end
                    STEP_Y2: begin
                        r_x2   <= nx2;
                        r_y2   <= r_a;
                        r_c2   <= {2'b00, nx2 > rs, nx2 < 0};
                        r_step <= STEP_CHK;
                    end
                    STEP_X1: begin
                        r_y1   <= r_y1 + q;
                        r_x1   <= r_a;
                        r_c1   <= 4'd0;
                        r_step <= STEP_X2;
                    end
                    default: begin
                        r_y2 <= r_y2 + q;
                        r_x2 <= r_a;
                        r_c2 <= 4'd0;
                    end
                endcase
            end
            ST_WSET: begin
                r_wx     <= r_x1[WALK_W-1:0];
                r_wy     <= r_y1[WALK_W-1:0];
                r_sxn    <= dx[WALK_W];
                r_syn    <= dy[WALK_W];
                r_swap   <= (ady > adx);
                r_err    <= $signed(ERR_W'(maj)) - $signed(ERR_W'({mnr, 1'b0}));
                r_inc_a  <= $signed(ERR_W'({maj, 1'b0})) - $signed(ERR_W'({mnr, 1'b0}));
                r_inc_b  <= $signed(ERR_W'({mnr, 1'b0}));
                r_left   <= {1'b0, maj} + 1'b1;
                r_pv     <= 1'b0;
                r_inside <= 1'b1;
                r_hit    <= 1'b0;
            end
            ST_WALK: begin
                if (hit_now) begin
                    r_hit <= 1'b1;
                    r_hx  <= r_px;
                    r_hy  <= r_py;
                end else if (r_left != '0) begin
                    r_px   <= r_wx;
                    r_py   <= r_wy;
                    r_pv   <= 1'b1;
                    r_left <= r_left - 1'b1;
                    if (wneg || !r_swap) r_wx <= r_wx + (r_sxn ? '1 : WALK_W'(1));
                    if (wneg || r_swap)  r_wy <= r_wy + (r_syn ? '1 : WALK_W'(1));
                    r_err <= wneg ? r_err + r_inc_a : r_err - r_inc_b;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    r_oin  <= r_inside;
                    r_ohit <= r_inside && r_hit;
                    r_ohx  <= (r_inside && r_hit) ? r_hx[CELL_W-1:0] : '0;
                    r_ohy  <= (r_inside && r_hit) ? r_hy[CELL_W-1:0] : '0;
                    r_osx  <= r_inside ? r_x1[CELL_W-1:0] : '0;
                    r_osy  <= r_inside ? r_y1[CELL_W-1:0] : '0;
                    r_oex  <= r_inside ? r_x2[CELL_W-1:0] : '0;
                    r_oey  <= r_inside ? r_y2[CELL_W-1:0] : '0;
                end
            end
            default: ;
        endcase
    end

    assign o_out.valid           = r_ov;
    assign o_out.inside_res      = r_oin;
    assign o_out.hit             = r_ohit;
    assign o_out.hit_x           = r_ohx;
    assign o_out.hit_y           = r_ohy;
    assign o_out.clipped_start_x = r_osx;
    assign o_out.clipped_start_y = r_osy;
    assign o_out.clipped_end_x   = r_oex;
    assign o_out.clipped_end_y   = r_oey;
endmodule

@@ hw/rtl/occupancy_grid_ray_trace.sv @@
// Channel   Dir  Beat contents
// i_in      in   kind, cell_x/y, cell_value, ray_start_x/y, ray_end_x/y
// o_out     out  inside_res, hit, hit_x/y, clipped_start_x/y, clipped_end_x/y
// i_cfg     in   addr (0 map_width, 1 map_height), data
//
// Cell write: done in the back end's idle state as it is popped. Trace: setup,
// up to four clip corrections (multiply, then a 36-step shift-subtract divide),
// then one map cell read per cycle, at most major+1 cells. After reset the
// map RAM is swept to free, one cell a cycle, over (MAX_SIDE rounded up to a
// power of two) squared cells; i_in is held off meanwhile.
// A two-beat queue and the output register let either side stall alone.
module occupancy_grid_ray_trace import ogrt_pkg::*; #(
    parameter int MAX_SIDE = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ogrt_in_if.sink     i_in,
    ogrt_out_if.source  o_out,
    ogrt_cfg_if.sink    i_cfg
);
    logic [CFG_W-1:0] r_map_w;
    logic [CFG_W-1:0] r_map_h;
    logic             cmd_valid;
    logic             cmd_pop;
    logic             hold;
    t_cmd             cmd;

    // Register writes land whenever offered; the user must send traffic only while idle, the block does not enforce it.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_w <= CFG_W'(256);
            r_map_h <= CFG_W'(256);
        end else if (i_cfg.valid) begin
            unique case (t_cfg_idx'(i_cfg.addr))
                CFG_MAP_WIDTH:  r_map_w <= i_cfg.data;
                CFG_MAP_HEIGHT: r_map_h <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // front: accept and classify beats into the queue
    ogrt_front #(.MAX_SIDE(MAX_SIDE)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_hold      (hold),
        .i_pop       (cmd_pop),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd)
    );

    // back: map writes, clipping, walk, result
    ogrt_back #(.MAX_SIDE(MAX_SIDE)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_hold      (hold),
        .i_map_w     (r_map_w),
        .i_map_h     (r_map_h),
        .o_out       (o_out)
    );
endmodule

@@ tb/sv/occupancy_grid_ray_trace_tb.sv @@
`timescale 1ns / 1ps

module occupancy_grid_ray_trace_tb;
    import ogrt_pkg::*;

    localparam int  SIDE        = 256;
    localparam bit  KIND_WRITE  = 1'b0;
    localparam bit  KIND_TRACE  = 1'b1;
    localparam int  SETTLE_CYC  = 40;    // back end finishing a cell write
    localparam int  TAIL_CYC    = 600;   // longest trace plus slack
    localparam int  HOLD_CYC    = 3000;  // long receiver hold-off

    typedef struct {
        bit                kind;
        bit [CELL_W-1:0]   cx;
        bit [CELL_W-1:0]   cy;
        bit [CELL_W-1:0]   cval;
        bit signed [RAY_W-1:0] sx;
        bit signed [RAY_W-1:0] sy;
        bit signed [RAY_W-1:0] ex;
        bit signed [RAY_W-1:0] ey;
    } t_ray_item;

    typedef struct {
        bit              in_map;
        bit              hit;
        bit [CELL_W-1:0] hx;
        bit [CELL_W-1:0] hy;
        bit [CELL_W-1:0] csx;
        bit [CELL_W-1:0] csy;
        bit [CELL_W-1:0] cex;
        bit [CELL_W-1:0] cey;
    } t_trace_res;

    logic i_clk;
    logic i_rst_n;

    ogrt_in_if  in_ch();
    ogrt_out_if out_ch();
    ogrt_cfg_if cfg_ch();

    occupancy_grid_ray_trace #(.MAX_SIDE(SIDE)) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source),
        .i_cfg   (cfg_ch.sink)
    );

    // Shadow of the block's state
    bit              occ_map [0:SIDE*SIDE-1];
    bit [CFG_W-1:0]  shadow_w = 9'd256;
    bit [CFG_W-1:0]  shadow_h = 9'd256;

    t_ray_item  pending_items[$];
    t_trace_res expected_traces[$];
    int         errors    = 0;
    int         beats_in  = 0;
    int         cyc       = 0;
    bit         hold_out  = 0;
    bit         in_fire;

    always begin
        i_clk = 1'b1; #4;
        i_clk = 1'b0; #4;
    end

    always @(posedge i_clk) cyc <= cyc + 1;

    // Random gaps, except in a recurring quiet window
    function automatic bit take_gap();
        if ((cyc % 40000) >= 30000) return 1'b0;
        return $urandom_range(99) < 38;
    endfunction

    function automatic longint eff_side(bit [CFG_W-1:0] v);
        return (v > SIDE) ? SIDE : longint'(v);
    endfunction

    function automatic longint tdiv(longint n, longint d);
        return (d == 0) ? 0 : n / d;
    endfunction

    function automatic int region(longint x, longint y, longint r, longint b);
        return int'(x < 0) + int'(x > r) * 2 + int'(y < 0) * 4 + int'(y > b) * 8;
    endfunction

    // Rows first, then columns; quotients truncate toward zero
    function automatic bit clip_to_map(inout longint x1, inout longint y1,
                                       inout longint x2, inout longint y2,
                                       input longint r, input longint b);
        int     c1, c2;
        longint a;
        c1 = region(x1, y1, r, b);
        c2 = region(x2, y2, r, b);
        if ((c1 & c2) == 0 && (c1 | c2) != 0) begin
            if (c1 & 12) begin
                a  = (c1 < 8) ? 0 : b;
                x1 += tdiv((a - y1) * (x2 - x1), y2 - y1);
                y1 = a;
                c1 = int'(x1 < 0) + int'(x1 > r) * 2;
            end
            if (c2 & 12) begin
                a  = (c2 < 8) ? 0 : b;
                x2 += tdiv((a - y2) * (x2 - x1), y2 - y1);
                y2 = a;
                c2 = int'(x2 < 0) + int'(x2 > r) * 2;
            end
            if ((c1 & c2) == 0 && (c1 | c2) != 0) begin
                if (c1 != 0) begin
                    a  = (c1 == 1) ? 0 : r;
                    y1 += tdiv((a - x1) * (y2 - y1), x2 - x1);
                    x1 = a;
                    c1 = 0;
                end
                if (c2 != 0) begin
                    a  = (c2 == 1) ? 0 : r;
                    y2 += tdiv((a - x2) * (y2 - y1), x2 - x1);
                    x2 = a;
                    c2 = 0;
                end
            end
        end
        return (c1 | c2) == 0;
    endfunction

    function automatic bit map_occ(longint x, longint y);
        if (x < 0 || y < 0 || x >= SIDE || y >= SIDE) return 1'b0;
        return occ_map[y * SIDE + x];
    endfunction

    // Appends one item to the driver's queue
    task automatic add_item(t_ray_item it);
        pending_items = {pending_items, it};
    endtask

    // Applies one accepted beat; a trace queues its expected result
    function automatic void apply_beat(t_ray_item it);
        t_trace_res res;
        longint w, h, x1, y1, x2, y2, dx, dy, stx, sty, major, minor, err, x, y;
        bit     steep;
        res = '{default: 0};
        if (it.kind == KIND_WRITE) begin
            occ_map[int'(it.cy) * SIDE + int'(it.cx)] = (it.cval != 0);
            return;
        end
        w = eff_side(shadow_w);
        h = eff_side(shadow_h);
        x1 = it.sx; y1 = it.sy; x2 = it.ex; y2 = it.ey;
        if (w != 0 && h != 0 && clip_to_map(x1, y1, x2, y2, w - 1, h - 1)) begin
            dx = x2 - x1; dy = y2 - y1;
            stx = (dx < 0) ? -1 : 1;
            sty = (dy < 0) ? -1 : 1;
            if (dx < 0) dx = -dx;
            if (dy < 0) dy = -dy;
            steep = dy > dx;                 // ties walk along x
            major = steep ? dy : dx;
            minor = steep ? dx : dy;
            err = major - 2 * minor;
            x = x1; y = y1;
            for (longint i = 0; i <= major; i++) begin
                if (map_occ(x, y)) begin
                    res.hit = 1'b1;
                    res.hx  = x[7:0];
                    res.hy  = y[7:0];
                    break;
                end
                if (err < 0) begin
                    err += 2 * major - 2 * minor;
                    x += stx; y += sty;
                end else begin
                    err -= 2 * minor;
                    if (steep) y += sty; else x += stx;
                end
            end
            res.in_map = 1'b1;
            res.csx = x1[7:0]; res.csy = y1[7:0];
            res.cex = x2[7:0]; res.cey = y2[7:0];
        end
        expected_traces = {expected_traces, res};
    endfunction

    task automatic report_mismatch(string field, int got, int want);
        $display("mismatch on %s at %0t: got %0d, expected %0d", field, $realtime, got, want);
        errors++;
    endtask

    // Input driver: holds the front item until its beat is taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            in_fire = in_ch.valid && in_ch.ready;
            if (in_fire) begin
                apply_beat(pending_items.pop_front());
                beats_in++;
            end
            if (!in_ch.valid || in_fire) begin
                if (pending_items.size() > 0 && !take_gap()) begin
                    in_ch.valid       <= 1'b1;
                    in_ch.kind        <= pending_items[0].kind;
                    in_ch.cell_x      <= pending_items[0].cx;
                    in_ch.cell_y      <= pending_items[0].cy;
                    in_ch.cell_value  <= pending_items[0].cval;
                    in_ch.ray_start_x <= pending_items[0].sx;
                    in_ch.ray_start_y <= pending_items[0].sy;
                    in_ch.ray_end_x   <= pending_items[0].ex;
                    in_ch.ray_end_y   <= pending_items[0].ey;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (expected_traces.size() == 0) begin
                    report_mismatch("unexpected beat", 1, 0);
                end else begin
                    t_trace_res want;
                    want = expected_traces.pop_front();
                    if (out_ch.inside_res !== want.in_map)
                        report_mismatch("inside_res", out_ch.inside_res, want.in_map);
                    if (out_ch.hit !== want.hit)
                        report_mismatch("hit", out_ch.hit, want.hit);
                    if (out_ch.hit_x !== want.hx)
                        report_mismatch("hit_x", out_ch.hit_x, want.hx);
                    if (out_ch.hit_y !== want.hy)
                        report_mismatch("hit_y", out_ch.hit_y, want.hy);
                    if (out_ch.clipped_start_x !== want.csx)
                        report_mismatch("clipped_start_x", out_ch.clipped_start_x, want.csx);
                    if (out_ch.clipped_start_y !== want.csy)
                        report_mismatch("clipped_start_y", out_ch.clipped_start_y, want.csy);
                    if (out_ch.clipped_end_x !== want.cex)
                        report_mismatch("clipped_end_x", out_ch.clipped_end_x, want.cex);
                    if (out_ch.clipped_end_y !== want.cey)
                        report_mismatch("clipped_end_y", out_ch.clipped_end_y, want.cey);
                end
            end
            out_ch.ready <= !hold_out && !take_gap();
        end
    end

    // Long receiver hold-off while the sender keeps offering beats
    initial begin
        do @(posedge i_clk); while (beats_in < 200);
        hold_out = 1'b1;
        repeat (HOLD_CYC) @(posedge i_clk);
        hold_out = 1'b0;
    end

    initial begin
        #50_000_000;
        $display("occupancy_grid_ray_trace regression: fail");
        $finish;
    end

    function automatic t_ray_item cell_write(int x, int y, int v);
        t_ray_item it;
        it = '{default: 0};
        it.kind = KIND_WRITE;
        it.cx = x[7:0]; it.cy = y[7:0]; it.cval = v[7:0];
        it.sx = $urandom; it.sy = $urandom; it.ex = $urandom; it.ey = $urandom;
        return it;
    endfunction

    function automatic t_ray_item ray(int x1, int y1, int x2, int y2);
        t_ray_item it;
        it = '{default: 0};
        it.kind = KIND_TRACE;
        it.cx = $urandom; it.cy = $urandom; it.cval = $urandom;
        it.sx = x1[15:0]; it.sy = y1[15:0]; it.ex = x2[15:0]; it.ey = y2[15:0];
        return it;
    endfunction

    function automatic int near_coord(int side);
        return $urandom_range(side + 40) - 20;
    endfunction

    // Cell writes and rays: rays mostly near the map, some from inside it to far away, some fully random
    function automatic t_ray_item random_item();
        int w, h, m;
        w = int'(eff_side(shadow_w)); if (w == 0) w = 1;
        h = int'(eff_side(shadow_h)); if (h == 0) h = 1;
        if ($urandom_range(99) < 45) begin
            if ($urandom_range(9) < 7)
                return cell_write($urandom_range(w - 1), $urandom_range(h - 1),
                                  ($urandom_range(3) == 0) ? $urandom_range(1, 255) : 0);
            return cell_write($urandom_range(255), $urandom_range(255), $urandom_range(255));
        end
        m = $urandom_range(99);
        if (m < 55)
            return ray(near_coord(w), near_coord(h), near_coord(w), near_coord(h));
        if (m < 80)
            return ray($urandom_range(w - 1), $urandom_range(h - 1),
                       $signed(16'($urandom)), $signed(16'($urandom)));
        return ray($signed(16'($urandom)), $signed(16'($urandom)),
                   $signed(16'($urandom)), $signed(16'($urandom)));
    endfunction

    task automatic wait_idle();
        do @(posedge i_clk); while (pending_items.size() != 0 || expected_traces.size() != 0);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, int value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.addr  <= idx;
        cfg_ch.data  <= value[CFG_W-1:0];
        do @(posedge i_clk); while (!(cfg_ch.valid && cfg_ch.ready));
        cfg_ch.valid <= 1'b0;
        if (idx == CFG_MAP_WIDTH) shadow_w = value[CFG_W-1:0];
        else                      shadow_h = value[CFG_W-1:0];
    endtask

    task automatic run_phase(int w, int h, int n_items);
        write_reg(CFG_MAP_WIDTH, w);
        write_reg(CFG_MAP_HEIGHT, h);
        repeat (n_items) add_item(random_item());
        wait_idle();
    endtask

    initial begin
        i_rst_n = 1'b0;
        cfg_ch.valid = 1'b0; cfg_ch.addr = '0; cfg_ch.data = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: map corners, extreme rays, ties, points, shared outside sides
        write_reg(CFG_MAP_WIDTH, 256);
        write_reg(CFG_MAP_HEIGHT, 256);
        add_item(ray(-32768, -32768, 32767, 32767));   // empty map
        add_item(cell_write(0, 0, 255));
        add_item(cell_write(255, 255, 1));
        add_item(cell_write(128, 40, 0));
        add_item(ray(-32768, -32768, 32767, 32767));   // diagonal, hits corner
        add_item(ray(32767, 32767, -32768, -32768));
        add_item(ray(10, 10, 10, 10));                 // single cell
        add_item(ray(0, 0, 0, 0));                     // single occupied cell
        add_item(ray(5, 200, 250, 200));               // horizontal
        add_item(ray(77, -5000, 77, 9000));            // vertical
        add_item(ray(20, 30, 60, 70));                 // dx == dy tie
        add_item(ray(-10, -10, -5, 300));              // both left
        add_item(ray(300, 5, 400, 9));                 // both right
        add_item(ray(3, -7, 200, -1));                 // both above
        add_item(ray(-300, 100, 600, 130));            // crosses both columns
        add_item(ray(-50, -60, 400, 700));             // corner region ends
        add_item(ray(-1, 300, 300, -1));               // misses corner
        add_item(cell_write(200, 60, 9));
        add_item(ray(255, 0, 0, 255));                 // anti-diagonal
        add_item(ray(0, 60, 255, 60));                 // hits mid-row
        add_item(ray(255, 255, 255, 255));
        wait_idle();

        run_phase(256, 256, 250);
        run_phase(1, 1, 150);       // single-cell map
        run_phase(256, 1, 200);
        run_phase(1, 256, 200);
        run_phase(0, 17, 120);      // empty map, every trace outside
        run_phase(40, 0, 80);
        run_phase(511, 300, 220);   // above the store side, saturates
        run_phase(37, 200, 200);    // small map, stored cells outside it
        run_phase(256, 256, 230);   // grows back over earlier writes

        repeat (TAIL_CYC) @(posedge i_clk);
        if (errors == 0) begin
            $display("occupancy_grid_ray_trace regression: pass");
        end else begin
            $display("occupancy_grid_ray_trace regression: fail");
        end
        $finish;
    end

endmodule
